>>> hw/rtl/dst_pkg.sv
package dst_pkg;

    // field widths of the channels
    localparam int ACTION_W = 2;
    localparam int NODE_W   = 16;
    localparam int STR_W    = 16;
    localparam int AGE_W    = 8;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 4;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_STRENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE      = 2'd2;

    // reset values: 0.95 and 0.1 in Q0.16, age limit 100
    localparam logic [STR_W-1:0] DECAY_FACTOR_RST = 16'd62259;
    localparam logic [STR_W-1:0] MIN_STRENGTH_RST = 16'd6554;
    localparam logic [AGE_W-1:0] MAX_AGE_RST      = 8'd100;

    // default geometry
    localparam int SLOTS_DEFAULT     = 8;
    localparam int NODE_BITS_DEFAULT = 16;

    // action codes of an input word
    localparam logic [ACTION_W-1:0] ACT_DECAY   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_OFFER   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READOUT = 2'd2;

    // status codes of a result word
    typedef enum logic [STATUS_W-1:0] {
        ST_DECAYED   = 3'd0,
        ST_REFRESHED = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_DROPPED   = 3'd3,
        ST_SLOT      = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    // source of data written into the slot memory
    typedef enum logic [1:0] {
        WR_DECAY,
        WR_REFRESH,
        WR_INSERT
    } wr_sel_t;

    // source of the slot fields of a result word
    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_OFFER,
        OUT_REFRESH,
        OUT_SLOT
    } out_sel_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic     capture;
        logic     rd_en;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     load_out;
        out_sel_t out_sel;
        status_t  out_status;
        logic     out_last;
        logic     set_used;
    } dst_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic match;
        logic keep;
        logic out_free;
    } dst_stat_t;

endpackage

>>> hw/rtl/dst_if.sv
interface dst_in_if;
    import dst_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [NODE_W-1:0]   offered_node;
    logic [STR_W-1:0]    offered_strength;

    modport source (output valid, action, offered_node, offered_strength, input ready);
    modport sink (input valid, action, offered_node, offered_strength, output ready);
endinterface

interface dst_out_if;
    import dst_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   slot_node;
    logic [STR_W-1:0]    slot_strength;
    logic [AGE_W-1:0]    slot_age;
    logic [OCC_W-1:0]    occupancy;
    logic                last;

    modport source (output valid, status, slot_node, slot_strength, slot_age, occupancy, last,
                    input ready);
    modport sink (input valid, status, slot_node, slot_strength, slot_age, occupancy, last,
                  output ready);
endinterface

>>> hw/rtl/decaying_slot_table.sv
// Ordered table of up to SLOTS slots (node id, Q0.16 strength, age) kept in a
// slot memory with one write and one registered read port. A decay word
// scales each strength by decay_factor (rounded half up), ages each slot by
// one, drops slots below min_strength or older than max_age and packs the
// rest in order; it returns one word, and its walk through the memory read
// port handles one slot per cycle. An offer word refreshes the matching slot
// or appends a new one (dropped when full). A readout word returns one word
// per slot in table order (an empty word when the table is empty), one per
// cycle while the result side takes them, from the registered read port.
// Action code 3 is ignored. New input is taken only when the previous word is
// fully processed; a finished result may still sit in the output register
// then. Slot contents need no clearing after reset.
module decaying_slot_table #(
    parameter int SLOTS     = dst_pkg::SLOTS_DEFAULT,
    parameter int NODE_BITS = dst_pkg::NODE_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [dst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dst_pkg::CFG_W-1:0]      cfg_data,
    dst_in_if.sink                         items,
    dst_out_if.source                      results
);
    import dst_pkg::*;

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    dst_cmd_t          cmd;
    dst_stat_t         stat;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic [CNT_W-1:0]  count_val;
    logic [CNT_W-1:0]  used;

    // sequencer
    dst_ctrl #(
        .SLOTS (SLOTS),
        .CNT_W (CNT_W),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_action (items.action),
        .in_ready  (items.ready),
        .stat      (stat),
        .used      (used),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .count_val (count_val)
    );

    // slot memory, arithmetic and output register
    dst_datapath #(
        .SLOTS     (SLOTS),
        .NODE_BITS (NODE_BITS),
        .CNT_W     (CNT_W),
        .IDX_W     (IDX_W)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .offered_node     (items.offered_node),
        .offered_strength (items.offered_strength),
        .cmd              (cmd),
        .rd_addr          (rd_addr),
        .wr_addr          (wr_addr),
        .count_val        (count_val),
        .stat             (stat),
        .used             (used),
        .results          (results)
    );

endmodule

>>> hw/rtl/dst_datapath.sv
module dst_datapath #(
    parameter int SLOTS     = dst_pkg::SLOTS_DEFAULT,
    parameter int NODE_BITS = dst_pkg::NODE_BITS_DEFAULT,
    parameter int CNT_W     = $clog2(SLOTS + 1),
    parameter int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_write,
    input  logic [dst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dst_pkg::CFG_W-1:0]       cfg_data,
    // input payload
    input  logic [dst_pkg::NODE_W-1:0]      offered_node,
    input  logic [dst_pkg::STR_W-1:0]       offered_strength,
    // controller link
    input  dst_pkg::dst_cmd_t               cmd,
    input  logic [IDX_W-1:0]                rd_addr,
    input  logic [IDX_W-1:0]                wr_addr,
    input  logic [CNT_W-1:0]                count_val,
    output dst_pkg::dst_stat_t              stat,
    output logic [CNT_W-1:0]                used,
    // result channel
    dst_out_if.source                       results
);
    import dst_pkg::*;

    localparam int NW = (NODE_BITS < NODE_W) ? NODE_BITS : NODE_W;
    localparam int PROD_W = 2 * STR_W;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (STR_W - 1);

    typedef struct packed {
        logic [NW-1:0]    node;
        logic [STR_W-1:0] strength;
        logic [AGE_W-1:0] age;
    } entry_t;

    entry_t              mem [SLOTS];
    entry_t              rd_data_reg;
    entry_t              wr_data;

    logic [STR_W-1:0]    decay_factor_reg;
    logic [STR_W-1:0]    min_strength_reg;
    logic [AGE_W-1:0]    max_age_reg;
    logic [CNT_W-1:0]    used_reg;
    logic [NW-1:0]       node_reg;
    logic [STR_W-1:0]    strength_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             out_status_reg;
    logic [NW-1:0]       out_node_reg;
    logic [STR_W-1:0]    out_strength_reg;
    logic [AGE_W-1:0]    out_age_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic                out_last_reg;

    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   rounded;
    logic [STR_W-1:0]    dec_strength;
    logic [AGE_W-1:0]    dec_age;
    logic [STR_W-1:0]    max_strength;
    logic [NW-1:0]       sel_node;
    logic [STR_W-1:0]    sel_strength;
    logic [AGE_W-1:0]    sel_age;
    logic [NW+NODE_W-1:0]  node_ext;
    logic [CNT_W+OCC_W-1:0] occ_ext;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_factor_reg <= DECAY_FACTOR_RST;
            min_strength_reg <= MIN_STRENGTH_RST;
            max_age_reg      <= MAX_AGE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DECAY_FACTOR: decay_factor_reg <= cfg_data[STR_W-1:0];
                REG_MIN_STRENGTH: min_strength_reg <= cfg_data[STR_W-1:0];
                REG_MAX_AGE:      max_age_reg      <= cfg_data[AGE_W-1:0];
                default:          ;
            endcase
        end
    end

    // fill count of the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.set_used)
        begin
            used_reg <= count_val;
        end
    end

    assign used = used_reg;

    // offered word, node id masked to the stored width
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            node_reg     <= offered_node[NW-1:0];
            strength_reg <= offered_strength;
        end
    end

    // decayed strength, rounded half up, and saturating age
    assign prod         = PROD_W'(rd_data_reg.strength) * PROD_W'(decay_factor_reg);
    assign rounded      = prod + HALF;
    assign dec_strength = rounded[PROD_W-1:STR_W];
    assign dec_age      = (rd_data_reg.age == '1) ? rd_data_reg.age : rd_data_reg.age + 1'b1;
    assign max_strength = (strength_reg > rd_data_reg.strength) ? strength_reg
                                                                 : rd_data_reg.strength;

    assign stat.keep     = (dec_strength >= min_strength_reg) && (dec_age <= max_age_reg);
    assign stat.match    = (rd_data_reg.node == node_reg);
    assign stat.out_free = !out_valid_reg || results.ready;

    // write data into the slot memory
    always_comb
    begin
        unique case (cmd.wr_sel)
            WR_DECAY:   wr_data = '{node: rd_data_reg.node, strength: dec_strength,
                                    age: dec_age};
            WR_REFRESH: wr_data = '{node: rd_data_reg.node, strength: max_strength,
                                    age: '0};
            WR_INSERT:  wr_data = '{node: node_reg, strength: strength_reg, age: '0};
            default:    wr_data = '{node: node_reg, strength: strength_reg, age: '0};
        endcase
    end

    // slot memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // slot fields of the next result word
    always_comb
    begin
        unique case (cmd.out_sel)
            OUT_ZERO:
            begin
                sel_node     = '0;
                sel_strength = '0;
                sel_age      = '0;
            end
            OUT_OFFER:
            begin
                sel_node     = node_reg;
                sel_strength = strength_reg;
                sel_age      = '0;
            end
            OUT_REFRESH:
            begin
                sel_node     = rd_data_reg.node;
                sel_strength = max_strength;
                sel_age      = '0;
            end
            OUT_SLOT:
            begin
                sel_node     = rd_data_reg.node;
                sel_strength = rd_data_reg.strength;
                sel_age      = rd_data_reg.age;
            end
            default:
            begin
                sel_node     = '0;
                sel_strength = '0;
                sel_age      = '0;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg   <= cmd.out_status;
            out_node_reg     <= sel_node;
            out_strength_reg <= sel_strength;
            out_age_reg      <= sel_age;
            out_count_reg    <= count_val;
            out_last_reg     <= cmd.out_last;
        end
    end

    // widen or trim to the port widths
    assign node_ext = {{NODE_W{1'b0}}, out_node_reg};
    assign occ_ext  = {{OCC_W{1'b0}}, out_count_reg};

    assign results.valid         = out_valid_reg;
    assign results.status        = out_status_reg;
    assign results.slot_node     = node_ext[NODE_W-1:0];
    assign results.slot_strength = out_strength_reg;
    assign results.slot_age      = out_age_reg;
    assign results.occupancy     = occ_ext[OCC_W-1:0];
    assign results.last          = out_last_reg;

endmodule

>>> hw/rtl/dst_ctrl.sv
module dst_ctrl #(
    parameter int SLOTS = dst_pkg::SLOTS_DEFAULT,
    parameter int CNT_W = $clog2(SLOTS + 1),
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [dst_pkg::ACTION_W-1:0]   in_action,
    output logic                           in_ready,
    input  dst_pkg::dst_stat_t             stat,
    input  logic [CNT_W-1:0]               used,
    output dst_pkg::dst_cmd_t              cmd,
    output logic [IDX_W-1:0]               rd_addr,
    output logic [IDX_W-1:0]               wr_addr,
    output logic [CNT_W-1:0]               count_val
);
    import dst_pkg::*;

    localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);
    localparam logic [CNT_W-1:0] SLOT_MAX = CNT_W'(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DC_WALK,
        S_DC_DONE,
        S_OF_WALK,
        S_OF_HIT,
        S_OF_MISS,
        S_RO_WALK,
        S_RO_EMPTY
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [CNT_W-1:0] keep_reg;
    logic [CNT_W-1:0] keep_next;
    logic [CNT_W-1:0] hit_idx;
    logic [CNT_W-1:0] used_inc;

    // idx_reg points one past the slot held in the read register
    assign hit_idx  = idx_reg - ONE;
    assign used_inc = used + ONE;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        keep_next      = keep_reg;
        in_ready       = 1'b0;
        rd_addr        = idx_reg[IDX_W-1:0];
        wr_addr        = keep_reg[IDX_W-1:0];
        count_val      = used;
        cmd            = '0;
        cmd.wr_sel     = WR_DECAY;
        cmd.out_sel    = OUT_ZERO;
        cmd.out_status = ST_DECAYED;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                rd_addr  = '0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    idx_next    = ONE;
                    keep_next   = '0;
                    priority if (in_action == ACT_DECAY)
                    begin
                        cmd.rd_en  = (used != '0);
                        state_next = (used != '0) ? S_DC_WALK : S_DC_DONE;
                    end
                    else if (in_action == ACT_OFFER)
                    begin
                        cmd.rd_en  = (used != '0);
                        state_next = (used != '0) ? S_OF_WALK : S_OF_MISS;
                    end
                    else if (in_action == ACT_READOUT)
                    begin
                        cmd.rd_en  = (used != '0);
                        state_next = (used != '0) ? S_RO_WALK : S_RO_EMPTY;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            // decay one slot per cycle and pack survivors downward
            S_DC_WALK:
            begin
                if (stat.keep)
                begin
                    cmd.wr_en = 1'b1;
                    keep_next = keep_reg + ONE;
                end
                if (idx_reg < used)
                begin
                    cmd.rd_en = 1'b1;
                    idx_next  = idx_reg + ONE;
                end
                else
                begin
                    state_next = S_DC_DONE;
                end
            end

            S_DC_DONE:
            begin
                count_val = keep_reg;
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.set_used = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            // search for the offered node
            S_OF_WALK:
            begin
                if (stat.match)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_REFRESH;
                    wr_addr    = hit_idx[IDX_W-1:0];
                    state_next = S_OF_HIT;
                end
                else if (idx_reg < used)
                begin
                    cmd.rd_en = 1'b1;
                    idx_next  = idx_reg + ONE;
                end
                else
                begin
                    state_next = S_OF_MISS;
                end
            end

            S_OF_HIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_sel    = OUT_REFRESH;
                    cmd.out_status = ST_REFRESHED;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            // append the offer, or drop it when the table is full
            S_OF_MISS:
            begin
                wr_addr = used[IDX_W-1:0];
                if (stat.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_sel    = OUT_OFFER;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                    if (used < SLOT_MAX)
                    begin
                        cmd.wr_en      = 1'b1;
                        cmd.wr_sel     = WR_INSERT;
                        cmd.set_used   = 1'b1;
                        cmd.out_status = ST_INSERTED;
                        count_val      = used_inc;
                    end
                    else
                    begin
                        cmd.out_status = ST_DROPPED;
                    end
                end
            end

            // one slot word per cycle while the output drains
            S_RO_WALK:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_sel    = OUT_SLOT;
                    cmd.out_status = ST_SLOT;
                    cmd.out_last   = (idx_reg == used);
                    if (idx_reg < used)
                    begin
                        cmd.rd_en = 1'b1;
                        idx_next  = idx_reg + ONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_RO_EMPTY:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_status = ST_EMPTY;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and walk counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            keep_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            keep_reg  <= keep_next;
        end
    end

endmodule

>>> sim/tb_decaying_slot_table.sv
module tb_decaying_slot_table;
    timeunit 1ns;
    timeprecision 1ps;

    import dst_pkg::*;

    localparam int SLOTS        = SLOTS_DEFAULT;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int POOL_SIZE    = 12;

    // action code that the block ignores
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        status_t           status;
        logic [NODE_W-1:0] node;
        logic [STR_W-1:0]  strength;
        logic [AGE_W-1:0]  age;
        logic [OCC_W-1:0]  occupancy;
        logic              last;
    } slot_word_t;

    typedef struct {
        logic                 is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        logic [ACTION_W-1:0]  act;
        logic [NODE_W-1:0]    node;
        logic [STR_W-1:0]     strength;
        logic                 typed;
        slot_word_t           want;
    } dir_row_t;

    typedef enum {MIX_TRAFFIC, AGING_RUN} traffic_t;

    typedef struct {
        logic [CFG_W-1:0] decay;
        logic [CFG_W-1:0] strength_floor;
        logic [CFG_W-1:0] age_limit;
        int               send_idle;
        int               recv_stall;
        int               count;
        traffic_t         style;
    } phase_t;

    localparam int DIR_ROWS = 25;
    localparam int PHASES   = 6;

    // directed rows; typed expectations only where they are obvious
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_READOUT, 16'h0000, 16'h0000, 1'b1,
          '{ST_EMPTY, 16'h0000, 16'h0000, 8'h00, 4'd0, 1'b1}},
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_DECAY, 16'h0000, 16'h0000, 1'b1,
          '{ST_DECAYED, 16'h0000, 16'h0000, 8'h00, 4'd0, 1'b1}},
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_UNUSED, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_OFFER, 16'h0000, 16'h0000, 1'b1,
          '{ST_INSERTED, 16'h0000, 16'h0000, 8'h00, 4'd1, 1'b1}},
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_OFFER, 16'hFFFF, 16'hFFFF, 1'b1,
          '{ST_INSERTED, 16'hFFFF, 16'hFFFF, 8'h00, 4'd2, 1'b1}},
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_OFFER, 16'h0000, 16'h0001, 1'b1,
          '{ST_REFRESHED, 16'h0000, 16'h0001, 8'h00, 4'd2, 1'b1}},
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_OFFER, 16'hFFFF, 16'h0000, 1'b1,
          '{ST_REFRESHED, 16'hFFFF, 16'hFFFF, 8'h00, 4'd2, 1'b1}},
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_OFFER, 16'h5555, 16'h8000, 1'b0, '0},
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_OFFER, 16'hAAAA, 16'h7FFF, 1'b0, '0},
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_OFFER, 16'h0003, 16'h1234, 1'b0, '0},
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_OFFER, 16'h0004, 16'h4000, 1'b0, '0},
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_OFFER, 16'h0005, 16'h2000, 1'b0, '0},
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_OFFER, 16'h0006, 16'h1000, 1'b0, '0},
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_OFFER, 16'h0007, 16'hFFFF, 1'b1,
          '{ST_DROPPED, 16'h0007, 16'hFFFF, 8'h00, 4'd8, 1'b1}},
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_READOUT, 16'h0000, 16'h0000, 1'b0, '0},
        // one half in Q0.16: a strength of one must round up and survive
        '{1'b1, REG_DECAY_FACTOR, 16'd32768, ACT_DECAY, 16'h0, 16'h0, 1'b0, '0},
        '{1'b1, REG_MIN_STRENGTH, 16'd0, ACT_DECAY, 16'h0, 16'h0, 1'b0, '0},
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_DECAY, 16'h0000, 16'h0000, 1'b0, '0},
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_READOUT, 16'h0000, 16'h0000, 1'b0, '0},
        // age limit zero empties the table on the next decay
        '{1'b1, REG_MAX_AGE, 16'd0, ACT_DECAY, 16'h0, 16'h0, 1'b0, '0},
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_DECAY, 16'h0000, 16'h0000, 1'b1,
          '{ST_DECAYED, 16'h0000, 16'h0000, 8'h00, 4'd0, 1'b1}},
        '{1'b0, REG_DECAY_FACTOR, 16'h0, ACT_READOUT, 16'h0000, 16'h0000, 1'b1,
          '{ST_EMPTY, 16'h0000, 16'h0000, 8'h00, 4'd0, 1'b1}},
        '{1'b1, REG_DECAY_FACTOR, DECAY_FACTOR_RST, ACT_DECAY, 16'h0, 16'h0, 1'b0, '0},
        '{1'b1, REG_MIN_STRENGTH, MIN_STRENGTH_RST, ACT_DECAY, 16'h0, 16'h0, 1'b0, '0},
        '{1'b1, REG_MAX_AGE, 16'(MAX_AGE_RST), ACT_DECAY, 16'h0, 16'h0, 1'b0, '0}
    };

    // random phases: register settings, idling and traffic shape
    phase_t phases [PHASES] = '{
        '{16'd62259, 16'd6554,  16'd100, 0,  0,  80,  MIX_TRAFFIC},
        '{16'd65535, 16'd0,     16'd255, 56, 0,  275, AGING_RUN},
        '{16'd65535, 16'd0,     16'd254, 0,  56, 30,  MIX_TRAFFIC},
        '{16'd0,     16'd65535, 16'd254, 0,  56, 60,  MIX_TRAFFIC},
        '{16'd40000, 16'd1000,  16'd10,  11, 11, 80,  MIX_TRAFFIC},
        '{16'd62259, 16'd6554,  16'd100, 0,  0,  40,  MIX_TRAFFIC}
    };

    logic clk;
    logic rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    dst_in_if  items_bus ();
    dst_out_if results_bus ();

    decaying_slot_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (items_bus),
        .results   (results_bus)
    );

    // table predictor state and its copy of the registers
    logic [NODE_W-1:0] tbl_node     [SLOTS];
    logic [STR_W-1:0]  tbl_strength [SLOTS];
    logic [AGE_W-1:0]  tbl_age      [SLOTS];
    int                tbl_used;
    logic [STR_W-1:0]  cur_decay;
    logic [STR_W-1:0]  cur_floor;
    logic [AGE_W-1:0]  cur_age_limit;

    slot_word_t step_words [$];
    slot_word_t awaited [$];
    slot_word_t mon_want;

    logic [NODE_W-1:0] node_pool [POOL_SIZE];
    int send_idle_pct;
    int recv_stall_pct;
    int errors;
    int words_seen;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic slot_word_t make_word(status_t st, logic [NODE_W-1:0] nd,
                                             logic [STR_W-1:0] sv, logic [AGE_W-1:0] ag,
                                             logic lst);
        slot_word_t w;
        w.status    = st;
        w.node      = nd;
        w.strength  = sv;
        w.age       = ag;
        w.occupancy = OCC_W'(tbl_used);
        w.last      = lst;
        return w;
    endfunction

    // apply one input word to the table copy and collect the words it causes
    task automatic table_step(input logic [ACTION_W-1:0] act, input logic [NODE_W-1:0] nd,
                              input logic [STR_W-1:0] sv);
        int kept;
        int hit;
        logic [31:0] prod;
        logic [STR_W-1:0] scaled;
        logic [AGE_W-1:0] older;
        step_words.delete();
        kept = 0;
        hit = -1;
        case (act)
            ACT_DECAY:
            begin
                for (int i = 0; i < tbl_used; i++)
                begin
                    prod   = 32'(tbl_strength[i]) * 32'(cur_decay) + 32'd32768;
                    scaled = prod[31:16];
                    older  = (tbl_age[i] == 8'hFF) ? 8'hFF : tbl_age[i] + 8'd1;
                    if (!(scaled < cur_floor || older > cur_age_limit))
                    begin
                        tbl_node[kept]     = tbl_node[i];
                        tbl_strength[kept] = scaled;
                        tbl_age[kept]      = older;
                        kept++;
                    end
                end
                tbl_used = kept;
                step_words = {step_words, make_word(ST_DECAYED, '0, '0, '0, 1'b1)};
            end
            ACT_OFFER:
            begin
                for (int i = 0; i < tbl_used; i++)
                    if (hit < 0 && tbl_node[i] == nd)
                        hit = i;
                if (hit >= 0)
                begin
                    if (sv > tbl_strength[hit])
                        tbl_strength[hit] = sv;
                    tbl_age[hit] = '0;
                    step_words = {step_words, make_word(ST_REFRESHED, tbl_node[hit],
                                                        tbl_strength[hit], '0, 1'b1)};
                end
                else if (tbl_used < SLOTS)
                begin
                    tbl_node[tbl_used]     = nd;
                    tbl_strength[tbl_used] = sv;
                    tbl_age[tbl_used]      = '0;
                    tbl_used++;
                    step_words = {step_words, make_word(ST_INSERTED, nd, sv, '0, 1'b1)};
                end
                else
                    step_words = {step_words, make_word(ST_DROPPED, nd, sv, '0, 1'b1)};
            end
            ACT_READOUT:
            begin
                if (tbl_used == 0)
                    step_words = {step_words, make_word(ST_EMPTY, '0, '0, '0, 1'b1)};
                for (int i = 0; i < tbl_used; i++)
                    step_words = {step_words, make_word(ST_SLOT, tbl_node[i],
                                                        tbl_strength[i], tbl_age[i],
                                                        i + 1 == tbl_used)};
            end
            default: ;
        endcase
    endtask

    task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch on word %0d: %s got %0h expected %0h", words_seen, what,
                 got, want);
    endtask

    // send one input word, with a random gap first
    task automatic send_word(input logic [ACTION_W-1:0] act, input logic [NODE_W-1:0] nd,
                             input logic [STR_W-1:0] sv, input logic typed,
                             input slot_word_t want);
        int gaps;
        gaps = 0;
        while ($urandom_range(99) < send_idle_pct)
            gaps++;
        if (gaps > 0)
        begin
            items_bus.valid <= 1'b0;
            repeat (gaps) @(negedge clk);
        end
        items_bus.valid            <= 1'b1;
        items_bus.action           <= act;
        items_bus.offered_node     <= nd;
        items_bus.offered_strength <= sv;
        @(posedge clk);
        while (items_bus.ready !== 1'b1)
            @(posedge clk);
        table_step(act, nd, sv);
        if (typed)
            awaited = {awaited, want};
        else
            awaited = {awaited, step_words};
        @(negedge clk);
    endtask

    // block is idle once every word has come back and it had time to settle
    task automatic wait_idle();
        items_bus.valid <= 1'b0;
        while (awaited.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_DECAY_FACTOR: cur_decay = val;
            REG_MIN_STRENGTH: cur_floor = val;
            REG_MAX_AGE:      cur_age_limit = val[AGE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // result side stalls at random
    always @(negedge clk)
        results_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

    // compare every accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && results_bus.valid === 1'b1 && results_bus.ready === 1'b1)
        begin
            words_seen++;
            if (awaited.size() == 0)
                flag("unexpected word, status", 32'(results_bus.status), 32'hFFFF_FFFF);
            else
            begin
                mon_want = awaited.pop_front();
                if (results_bus.status !== mon_want.status)
                    flag("status", 32'(results_bus.status), 32'(mon_want.status));
                if (results_bus.slot_node !== mon_want.node)
                    flag("slot_node", 32'(results_bus.slot_node), 32'(mon_want.node));
                if (results_bus.slot_strength !== mon_want.strength)
                    flag("slot_strength", 32'(results_bus.slot_strength),
                         32'(mon_want.strength));
                if (results_bus.slot_age !== mon_want.age)
                    flag("slot_age", 32'(results_bus.slot_age), 32'(mon_want.age));
                if (results_bus.occupancy !== mon_want.occupancy)
                    flag("occupancy", 32'(results_bus.occupancy), 32'(mon_want.occupancy));
                if (results_bus.last !== mon_want.last)
                    flag("last", 32'(results_bus.last), 32'(mon_want.last));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin : main
        logic [ACTION_W-1:0] act;
        logic [NODE_W-1:0]   nd;
        logic [STR_W-1:0]    sv;
        int pick;
        // drive everything known and hold reset
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        items_bus.valid = 1'b0;
        items_bus.action = ACT_DECAY;
        items_bus.offered_node = '0;
        items_bus.offered_strength = '0;
        tbl_used = 0;
        cur_decay = DECAY_FACTOR_RST;
        cur_floor = MIN_STRENGTH_RST;
        cur_age_limit = MAX_AGE_RST;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].is_reg)
            begin
                wait_idle();
                write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
            end
            else
                send_word(dir_rows[r].act, dir_rows[r].node, dir_rows[r].strength,
                          dir_rows[r].typed, dir_rows[r].want);
        end

        // random phases, registers rewritten while idle
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            send_idle_pct = 0;
            recv_stall_pct = phases[p].recv_stall;
            write_reg(REG_DECAY_FACTOR, phases[p].decay);
            write_reg(REG_MIN_STRENGTH, phases[p].strength_floor);
            write_reg(REG_MAX_AGE, phases[p].age_limit);
            send_idle_pct = phases[p].send_idle;
            foreach (node_pool[i])
                node_pool[i] = NODE_W'($urandom);
            for (int k = 0; k < phases[p].count; k++)
            begin
                pick = $urandom_range(99);
                nd = ($urandom_range(99) < 80) ? node_pool[$urandom_range(POOL_SIZE - 1)]
                                               : NODE_W'($urandom);
                sv = STR_W'($urandom);
                if (phases[p].style == AGING_RUN)
                begin
                    // fill the table once, then mostly age it
                    if (k < SLOTS)
                    begin
                        act = ACT_OFFER;
                        nd = node_pool[k];
                    end
                    else
                        act = (pick < 95) ? ACT_DECAY : ACT_READOUT;
                end
                else
                begin
                    if (pick < 45)
                        act = ACT_OFFER;
                    else if (pick < 70)
                        act = ACT_DECAY;
                    else if (pick < 94)
                        act = ACT_READOUT;
                    else
                        act = ACT_UNUSED;
                    pick = $urandom_range(99);
                    if (pick < 10)
                        sv = '0;
                    else if (pick < 20)
                        sv = '1;
                end
                send_word(act, nd, sv, 1'b0, '0);
            end
        end

        wait_idle();
        if (errors == 0 && awaited.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> decaying_slot_table.f
hw/rtl/dst_pkg.sv
hw/rtl/dst_if.sv
hw/rtl/dst_datapath.sv
hw/rtl/dst_ctrl.sv
hw/rtl/decaying_slot_table.sv
sim/tb_decaying_slot_table.sv
